// ----- rtl/sha1md_pkg.sv -----
package sha1md_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN_LO,
      ST_CMP_PRE,
      ST_CMP_RND,
      ST_CMP_ADD,
      ST_FIN
   } sha1md_state_type;

   typedef logic [31:0] word_type;

   localparam int WORDS_PER_BLOCK = 16;
   localparam int DIGEST_WORDS    = 5;

   localparam logic [6:0] ROUND_LAST = 7'd79;

   localparam logic [5:0] FILL_LAST_BYTE = 6'd63;
   localparam logic [5:0] FILL_LAST_WORD = 6'd60;
   localparam logic [5:0] FILL_LENGTH    = 6'd56;
   localparam logic [3:0] ADDR_LEN_HI    = 4'd14;
   localparam logic [3:0] ADDR_LEN_LO    = 4'd15;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [7:0] PAD_ZERO = 8'h00;

   localparam word_type IV_WORDS [DIGEST_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   function automatic word_type round_f(input logic [6:0] t, input word_type b,
                                        input word_type c, input word_type d);
      word_type f;
      if (t < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (t < 7'd40) begin
         f = b ^ c ^ d;
      end else if (t < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

   function automatic word_type round_k(input logic [6:0] t);
      word_type k;
      if (t < 7'd20) begin
         k = 32'h5A827999;
      end else if (t < 7'd40) begin
         k = 32'h6ED9EBA1;
      end else if (t < 7'd60) begin
         k = 32'h8F1BBCDC;
      end else begin
         k = 32'hCA62C1D6;
      end
      return k;
   endfunction

endpackage

// ----- rtl/sha1_message_digest_core.sv -----
// SHA-1 hashing core, one message byte per input transfer.
// The req channel carries req_data_byte, req_byte_present and req_message_end
// under a valid/ready handshake. A transfer with req_byte_present low and
// req_message_end low changes nothing. The transfer that fills a 64-byte
// block is followed by a compression (one memory read setup, 80 rounds at
// one round per cycle, one chaining add) during which no transfer is taken.
// After the transfer with req_message_end high, the core pads the block in
// the block memory (byte steps up to word alignment, then one word a cycle
// while no compression runs), writes the bit length and runs the
// last compression.
// The rsp channel then gives five transfers, most significant digest word
// first, with rsp_word_index 0 to 4 and rsp_final_word on the last one.
// The digest sits in its own output register, so the next message is taken
// while the receiver stalls; a second digest waits until the first has left.
// Synchronous reset loads the initial vector and clears the length and fill
// state; the block memory needs no clearing.
module sha1_message_digest_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_byte_present,
   input  logic                        req_message_end,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output sha1md_pkg::word_type        rsp_digest_word,
   output logic [2:0]                  rsp_word_index,
   output logic                        rsp_final_word
);
   import sha1md_pkg::*;

   sha1md_state_type state_ff, state_in;

   word_type   buf_mem_ff [WORDS_PER_BLOCK];
   word_type   mem_rdata_ff;
   logic       mem_we;
   logic [3:0] mem_waddr;
   word_type   mem_wdata;
   logic [3:0] mem_raddr;

   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bitlen_ff, bitlen_in;
   logic        pad_ff, pad_in;
   logic        pad80_ff, pad80_in;
   logic        last_ff, last_in;
   logic [6:0]  t_ff, t_in;
   word_type    acc_ff, acc_in;
   word_type    chain_ff [DIGEST_WORDS];
   word_type    chain_in [DIGEST_WORDS];
   word_type    a_ff, b_ff, c_ff, d_ff, e_ff;
   word_type    a_in, b_in, c_in, d_in, e_in;
   word_type    win_ff [WORDS_PER_BLOCK];
   word_type    win_in [WORDS_PER_BLOCK];
   word_type    dig_ff [DIGEST_WORDS];
   word_type    dig_in [DIGEST_WORDS];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_idx_ff, rsp_idx_in;

   logic       accept;
   logic       byte_push;
   logic       word_push;
   logic       len_write;
   logic       block_full;
   logic [7:0] push_val;
   logic       dig_load;
   word_type   wt;
   word_type   sched;
   word_type   round_sum;

   assign req_ready       = (state_ff == ST_IDLE);
   assign accept          = req_valid && req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = dig_ff[0];
   assign rsp_word_index  = rsp_idx_ff;
   assign rsp_final_word  = (rsp_idx_ff == 3'(DIGEST_WORDS - 1));

   always_comb begin
      byte_push  = (accept && req_byte_present) ||
                   ((state_ff == ST_PAD) && (!pad80_ff || (fill_ff[1:0] != 2'd0)));
      push_val   = (state_ff == ST_IDLE) ? req_data_byte : (pad80_ff ? PAD_ZERO : PAD_MARK);
      word_push  = (state_ff == ST_PAD) && pad80_ff && (fill_ff[1:0] == 2'd0) &&
                   (fill_ff != FILL_LENGTH);
      len_write  = (state_ff == ST_PAD) && pad80_ff && (fill_ff == FILL_LENGTH);
      block_full = (byte_push && (fill_ff == FILL_LAST_BYTE)) ||
                   (word_push && (fill_ff == FILL_LAST_WORD));
      dig_load   = (state_ff == ST_FIN) && !rsp_valid_ff;
      sched      = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
      wt         = (t_ff < 7'(WORDS_PER_BLOCK)) ? mem_rdata_ff : {sched[30:0], sched[31]};
      round_sum  = {a_ff[26:0], a_ff[31:27]} + round_f(t_ff, b_ff, c_ff, d_ff) + e_ff +
                   round_k(t_ff) + wt;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (block_full) begin
                  state_in = ST_CMP_PRE;
               end else if (req_message_end) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (block_full) begin
               state_in = ST_CMP_PRE;
            end else if (len_write) begin
               state_in = ST_LEN_LO;
            end
         end
         ST_LEN_LO:  state_in = ST_CMP_PRE;
         ST_CMP_PRE: state_in = ST_CMP_RND;
         ST_CMP_RND: begin
            if (t_ff == ROUND_LAST) begin
               state_in = ST_CMP_ADD;
            end
         end
         ST_CMP_ADD: begin
            if (last_ff) begin
               state_in = ST_FIN;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FIN: begin
            if (dig_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = fill_ff[5:2];
      mem_wdata = '0;
      mem_raddr = (state_ff == ST_CMP_PRE) ? 4'd0 : 4'(t_ff + 7'd1);
      acc_in    = acc_ff;
      fill_in   = fill_ff;
      bitlen_in = bitlen_ff;
      pad_in    = pad_ff;
      pad80_in  = pad80_ff;
      last_in   = last_ff;
      t_in      = t_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      e_in      = e_ff;
      win_in    = win_ff;
      chain_in  = chain_ff;
      dig_in    = dig_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;

      if (byte_push) begin
         case (fill_ff[1:0])
            2'd0:    acc_in[31:24] = push_val;
            2'd1:    acc_in[23:16] = push_val;
            2'd2:    acc_in[15:8]  = push_val;
            default: begin
               mem_we    = 1'b1;
               mem_wdata = {acc_ff[31:8], push_val};
            end
         endcase
         fill_in = fill_ff + 6'd1;
      end
      if (word_push) begin
         mem_we  = 1'b1;
         fill_in = fill_ff + 6'd4;
      end
      if (len_write) begin
         mem_we    = 1'b1;
         mem_waddr = ADDR_LEN_HI;
         mem_wdata = bitlen_ff[63:32];
      end
      if (accept && req_byte_present) begin
         bitlen_in = bitlen_ff + 64'd8;
      end
      if (accept && req_message_end) begin
         pad_in = 1'b1;
      end
      if ((state_ff == ST_PAD) && !pad80_ff) begin
         pad80_in = 1'b1;
      end

      case (state_ff)
         ST_LEN_LO: begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_LEN_LO;
            mem_wdata = bitlen_ff[31:0];
            fill_in   = '0;
            last_in   = 1'b1;
         end
         ST_CMP_PRE: begin
            t_in = '0;
            a_in = chain_ff[0];
            b_in = chain_ff[1];
            c_in = chain_ff[2];
            d_in = chain_ff[3];
            e_in = chain_ff[4];
         end
         ST_CMP_RND: begin
            t_in = t_ff + 7'd1;
            a_in = round_sum;
            b_in = a_ff;
            c_in = {b_ff[1:0], b_ff[31:2]};
            d_in = c_ff;
            e_in = d_ff;
            for (int i = 0; i < WORDS_PER_BLOCK - 1; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[WORDS_PER_BLOCK - 1] = wt;
         end
         ST_CMP_ADD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            chain_in[4] = chain_ff[4] + e_ff;
         end
         default: begin
         end
      endcase

      if (rsp_valid_ff && rsp_ready) begin
         for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
            dig_in[i] = dig_ff[i + 1];
         end
         rsp_idx_in = rsp_idx_ff + 3'd1;
         if (rsp_idx_ff == 3'(DIGEST_WORDS - 1)) begin
            rsp_valid_in = 1'b0;
         end
      end
      if (dig_load) begin
         dig_in       = chain_ff;
         rsp_valid_in = 1'b1;
         rsp_idx_in   = '0;
         chain_in     = IV_WORDS;
         fill_in      = '0;
         bitlen_in    = '0;
         pad_in       = 1'b0;
         pad80_in     = 1'b0;
         last_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         buf_mem_ff[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= buf_mem_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         bitlen_ff    <= '0;
         pad_ff       <= 1'b0;
         pad80_ff     <= 1'b0;
         last_ff      <= 1'b0;
         t_ff         <= '0;
         chain_ff     <= IV_WORDS;
         rsp_valid_ff <= 1'b0;
         rsp_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         bitlen_ff    <= bitlen_in;
         pad_ff       <= pad_in;
         pad80_ff     <= pad80_in;
         last_ff      <= last_in;
         t_ff         <= t_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_idx_ff   <= rsp_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
      win_ff <= win_in;
      dig_ff <= dig_in;
   end

`ifndef ASSERT_OFF
   a_len_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEN_LO) |-> (fill_ff == FILL_LENGTH))
      else $error("Length word written at a misaligned fill count.");

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP_RND) |-> (t_ff <= ROUND_LAST))
      else $error("Round counter ran past the last round.");

   a_no_write_in_rounds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CMP_RND) || (state_ff == ST_CMP_PRE)) |-> !mem_we)
      else $error("Block memory written during a compression.");

   a_digest_start: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FIN) && !rsp_valid_ff) |=> (rsp_valid_ff && (rsp_idx_ff == 3'd0)))
      else $error("Digest did not start with the first word.");
`endif

endmodule
